FILE: src/cau_pkg.sv
// Package for the complex arithmetic unit: word format, opcodes and the
// queue entry that the front half hands to the back half.
// No dependencies.
`timescale 1ns / 1ps

package cau_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int OPC_BITS   = 3;
    localparam int MAG_BITS   = 2 * WORD_BITS;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [OPC_BITS-1:0] OP_ADD  = 3'd0;
    localparam logic [OPC_BITS-1:0] OP_SUB  = 3'd1;
    localparam logic [OPC_BITS-1:0] OP_MUL  = 3'd2;
    localparam logic [OPC_BITS-1:0] OP_DIV  = 3'd3;
    localparam logic [OPC_BITS-1:0] OP_NEG  = 3'd4;
    localparam logic [OPC_BITS-1:0] OP_MAG  = 3'd5;
    localparam logic [OPC_BITS-1:0] OP_NORM = 3'd6;
    localparam logic [OPC_BITS-1:0] OP_EQ   = 3'd7;

    typedef logic [WORD_BITS-1:0] t_word;

    // One classified request: raw operands plus their sign and magnitude.
    typedef struct packed {
        logic [OPC_BITS-1:0] op;
        logic                eq;
        t_word               a_re;
        t_word               a_im;
        t_word               b_re;
        t_word               b_im;
        t_word               m_ar;
        t_word               m_ai;
        t_word               m_br;
        t_word               m_bi;
        logic                neg_ar;
        logic                neg_ai;
        logic                neg_br;
        logic                neg_bi;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: src/cau_if.sv
// Handshake channels of the complex arithmetic unit: request and response.
// Depends on cau_pkg.
`timescale 1ns / 1ps

interface cau_req_if;
    logic                               valid;
    logic                               ready;
    logic [cau_pkg::OPC_BITS-1:0]       opcode;
    logic signed [cau_pkg::WORD_BITS-1:0] a_re;
    logic signed [cau_pkg::WORD_BITS-1:0] a_im;
    logic signed [cau_pkg::WORD_BITS-1:0] b_re;
    logic signed [cau_pkg::WORD_BITS-1:0] b_im;

    modport source (output valid, opcode, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, opcode, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [cau_pkg::WORD_BITS-1:0] res_re;
    logic signed [cau_pkg::WORD_BITS-1:0] res_im;
    logic                               equal;
    logic                               div_by_zero;
    logic                               overflow;

    modport source (output valid, res_re, res_im, equal, div_by_zero, overflow,
                    input ready);
    modport sink   (input valid, res_re, res_im, equal, div_by_zero, overflow,
                    output ready);
endinterface

FILE: src/cau_front.sv
// Front half: takes requests, splits operands into sign and magnitude and
// settles the compare result. Depends on cau_pkg and cau_if.
`timescale 1ns / 1ps

module cau_front (
    cau_req_if.sink           i_req,
    input  cau_pkg::t_q_stat  i_stat,
    output logic              o_push,
    output cau_pkg::t_item    o_item
);

    localparam int W = cau_pkg::WORD_BITS;

    assign i_req.ready = !i_stat.full;
    assign o_push      = i_req.valid && !i_stat.full;

    always_comb begin
        o_item.op     = i_req.opcode;
        o_item.a_re   = i_req.a_re;
        o_item.a_im   = i_req.a_im;
        o_item.b_re   = i_req.b_re;
        o_item.b_im   = i_req.b_im;
        o_item.neg_ar = i_req.a_re[W-1];
        o_item.neg_ai = i_req.a_im[W-1];
        o_item.neg_br = i_req.b_re[W-1];
        o_item.neg_bi = i_req.b_im[W-1];
        // The magnitude of the most negative word still fits unsigned.
        o_item.m_ar   = i_req.a_re[W-1] ? (~i_req.a_re + 1'b1) : i_req.a_re;
        o_item.m_ai   = i_req.a_im[W-1] ? (~i_req.a_im + 1'b1) : i_req.a_im;
        o_item.m_br   = i_req.b_re[W-1] ? (~i_req.b_re + 1'b1) : i_req.b_re;
        o_item.m_bi   = i_req.b_im[W-1] ? (~i_req.b_im + 1'b1) : i_req.b_im;
        o_item.eq     = (i_req.opcode == cau_pkg::OP_EQ) && (i_req.a_re == i_req.b_re)
                        && (i_req.a_im == i_req.b_im);
    end

endmodule

FILE: src/cau_fifo.sv
// Short queue of classified requests between the front and back halves.
// Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cau_pkg::t_item    i_item,
    input  logic              i_pop,
    output cau_pkg::t_item    o_head,
    output cau_pkg::t_q_stat  o_stat
);

    localparam int AW = cau_pkg::FIFO_AW;

    cau_pkg::t_item r_mem [cau_pkg::FIFO_DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [AW:0]    r_cnt;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == (AW+1)'(cau_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

FILE: src/cau_back.sv
// Back half: multiply, combine, radix-2 divide and square root pipeline,
// rounding and saturation, with the response register at its end.
// Depends on cau_pkg and cau_if.
`timescale 1ns / 1ps

module cau_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cau_pkg::t_item    i_head,
    input  cau_pkg::t_q_stat  i_stat,
    output logic              o_pop,
    cau_rsp_if.source         o_rsp
);

    localparam int W     = cau_pkg::WORD_BITS;
    localparam int F     = cau_pkg::FRAC_BITS;
    localparam int MW    = cau_pkg::MAG_BITS;
    localparam int SHIFT = W - F;
    localparam int OB    = cau_pkg::OPC_BITS;
    localparam logic [MW:0] HALF = (MW+1)'(1) << (F - 1);
    localparam logic [MW:0] TOP  = (MW+1)'(1) << (W - 1);

    typedef struct packed {
        logic [OB-1:0]        op;
        logic                 eq;
        logic [5:0][MW-1:0]   p;
        logic [3:0]           ps;
        logic [W:0]           ex_re;
        logic [W:0]           ex_im;
    } t_sa;

    typedef struct packed {
        logic [OB-1:0] op;
        logic          eq;
        logic [MW:0]   v_re;
        logic [MW:0]   v_im;
        logic [MW-1:0] den;
    } t_sb;

    typedef struct packed {
        logic [OB-1:0] op;
        logic          eq;
        logic          neg_re;
        logic          neg_im;
        logic [MW-1:0] m_re;
        logic [MW-1:0] m_im;
        logic [MW-1:0] den;
        logic [MW:0]   x_re;
        logic [MW:0]   x_im;
        logic [W-1:0]  q_re;
        logic [W-1:0]  q_im;
        logic          big_re;
        logic          big_im;
    } t_sd;

    typedef struct packed {
        logic        eq;
        logic        dz;
        logic        neg_re;
        logic        neg_im;
        logic [MW:0] c_re;
        logic [MW:0] c_im;
    } t_se;

    logic         en;
    logic         r_vld_a, r_vld_b, r_vld_c, r_vld_e, r_out_vld;
    logic [W:0]   r_vld_d;
    t_sa          r_a, n_a;
    t_sb          r_b, n_b;
    t_sd          r_c, n_c;
    t_sd          r_d [W+1];
    t_sd          n_d0;
    t_se          r_e, n_e;

    // The whole pipe moves whenever the response register can take a value.
    assign en    = !r_out_vld || o_rsp.ready;
    assign o_pop = en && !i_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a   <= 1'b0;
            r_vld_b   <= 1'b0;
            r_vld_c   <= 1'b0;
            r_vld_d   <= '0;
            r_vld_e   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld_a   <= !i_stat.empty;
            r_vld_b   <= r_vld_a;
            r_vld_c   <= r_vld_b;
            r_vld_d   <= {r_vld_d[W-1:0], r_vld_c};
            r_vld_e   <= r_vld_d[W];
            r_out_vld <= r_vld_e;
        end
    end

    // Stage A: six magnitude products and the exact add, subtract, negate.
    always_comb begin
        logic           sq;
        logic [W-1:0]   x4;
        logic [W-1:0]   x5;
        logic [W:0]     ar;
        logic [W:0]     ai;
        logic [W:0]     br;
        logic [W:0]     bi;
        sq = (i_head.op == cau_pkg::OP_MAG) || (i_head.op == cau_pkg::OP_NORM);
        x4 = sq ? i_head.m_ar : i_head.m_br;
        x5 = sq ? i_head.m_ai : i_head.m_bi;
        ar = {i_head.a_re[W-1], i_head.a_re};
        ai = {i_head.a_im[W-1], i_head.a_im};
        br = {i_head.b_re[W-1], i_head.b_re};
        bi = {i_head.b_im[W-1], i_head.b_im};
        n_a.op    = i_head.op;
        n_a.eq    = i_head.eq;
        n_a.p[0]  = i_head.m_ar * i_head.m_br;
        n_a.p[1]  = i_head.m_ai * i_head.m_bi;
        n_a.p[2]  = i_head.m_ai * i_head.m_br;
        n_a.p[3]  = i_head.m_ar * i_head.m_bi;
        n_a.p[4]  = x4 * x4;
        n_a.p[5]  = x5 * x5;
        n_a.ps[0] = i_head.neg_ar ^ i_head.neg_br;
        n_a.ps[1] = i_head.neg_ai ^ i_head.neg_bi;
        n_a.ps[2] = i_head.neg_ai ^ i_head.neg_br;
        n_a.ps[3] = i_head.neg_ar ^ i_head.neg_bi;
        case (i_head.op)
            cau_pkg::OP_ADD: begin
                n_a.ex_re = ar + br;
                n_a.ex_im = ai + bi;
            end
            cau_pkg::OP_SUB: begin
                n_a.ex_re = ar - br;
                n_a.ex_im = ai - bi;
            end
            cau_pkg::OP_NEG: begin
                n_a.ex_re = '0 - ar;
                n_a.ex_im = '0 - ai;
            end
            default: begin
                n_a.ex_re = '0;
                n_a.ex_im = '0;
            end
        endcase
    end

    // Stage B: signed sums of the products, one four-input add per part.
    always_comb begin
        logic        s1;
        logic        s3;
        logic [MW:0] t0;
        logic [MW:0] t1;
        logic [MW:0] t2;
        logic [MW:0] t3;
        s1 = r_a.ps[1] ^ (r_a.op == cau_pkg::OP_MUL);
        s3 = r_a.ps[3] ^ (r_a.op == cau_pkg::OP_DIV);
        t0 = r_a.ps[0] ? ~{1'b0, r_a.p[0]} : {1'b0, r_a.p[0]};
        t1 = s1        ? ~{1'b0, r_a.p[1]} : {1'b0, r_a.p[1]};
        t2 = r_a.ps[2] ? ~{1'b0, r_a.p[2]} : {1'b0, r_a.p[2]};
        t3 = s3        ? ~{1'b0, r_a.p[3]} : {1'b0, r_a.p[3]};
        n_b.op  = r_a.op;
        n_b.eq  = r_a.eq;
        n_b.den = r_a.p[4] + r_a.p[5];
        if (r_a.op inside {cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_NEG}) begin
            n_b.v_re = {{(MW-W){r_a.ex_re[W]}}, r_a.ex_re};
            n_b.v_im = {{(MW-W){r_a.ex_im[W]}}, r_a.ex_im};
        end else if (r_a.op inside {cau_pkg::OP_MUL, cau_pkg::OP_DIV}) begin
            n_b.v_re = t0 + t1 + (MW+1)'(r_a.ps[0]) + (MW+1)'(s1);
            n_b.v_im = t2 + t3 + (MW+1)'(r_a.ps[2]) + (MW+1)'(s3);
        end else begin
            n_b.v_re = '0;
            n_b.v_im = '0;
        end
    end

    // Stage C: back to sign and magnitude.
    always_comb begin
        logic [MW:0] av_re;
        logic [MW:0] av_im;
        av_re = r_b.v_re[MW] ? (~r_b.v_re + 1'b1) : r_b.v_re;
        av_im = r_b.v_im[MW] ? (~r_b.v_im + 1'b1) : r_b.v_im;
        n_c        = '0;
        n_c.op     = r_b.op;
        n_c.eq     = r_b.eq;
        n_c.den    = r_b.den;
        n_c.neg_im = r_b.v_im[MW];
        n_c.m_im   = av_im[MW-1:0];
        if (r_b.op == cau_pkg::OP_NORM) begin
            n_c.neg_re = 1'b0;
            n_c.m_re   = r_b.den;
        end else begin
            n_c.neg_re = r_b.v_re[MW];
            n_c.m_re   = av_re[MW-1:0];
        end
    end

    // First divider stage: the top of the numerator becomes the partial
    // remainder, and a quotient of a full word or more is caught here.
    always_comb begin
        n_d0        = r_c;
        n_d0.q_re   = '0;
        n_d0.q_im   = '0;
        n_d0.big_re = (r_c.m_re >> SHIFT) >= r_c.den;
        n_d0.big_im = (r_c.m_im >> SHIFT) >= r_c.den;
        if (r_c.op == cau_pkg::OP_MAG) begin
            n_d0.x_re = {1'b0, r_c.den};
            n_d0.x_im = '0;
        end else begin
            n_d0.x_re = (MW+1)'(r_c.m_re >> SHIFT);
            n_d0.x_im = (MW+1)'(r_c.m_im >> SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a    <= n_a;
            r_b    <= n_b;
            r_c    <= n_c;
            r_d[0] <= n_d0;
            r_e    <= n_e;
        end
    end

    // One quotient bit per stage for both parts, or one root bit for magnitude.
    for (genvar j = 1; j <= W; j++) begin : g_step
        localparam int I = W - j;
        localparam logic [MW:0] BSQ = (MW+1)'(1) << (2 * I);

        logic        bit_re;
        logic        bit_im;
        logic [MW:0] r2_re;
        logic [MW:0] r2_im;
        logic [MW:0] t_sq;
        t_sd         n_s;

        if (I >= F) begin : g_num
            assign bit_re = r_d[j-1].m_re[I-F];
            assign bit_im = r_d[j-1].m_im[I-F];
        end else begin : g_pad
            assign bit_re = 1'b0;
            assign bit_im = 1'b0;
        end

        assign r2_re = {r_d[j-1].x_re[MW-1:0], bit_re};
        assign r2_im = {r_d[j-1].x_im[MW-1:0], bit_im};
        assign t_sq  = r_d[j-1].x_im + BSQ;

        always_comb begin
            n_s = r_d[j-1];
            if (r_d[j-1].op == cau_pkg::OP_MAG) begin
                if (r_d[j-1].x_re >= t_sq) begin
                    n_s.x_re = r_d[j-1].x_re - t_sq;
                    n_s.x_im = (r_d[j-1].x_im >> 1) + BSQ;
                end else begin
                    n_s.x_im = r_d[j-1].x_im >> 1;
                end
            end else begin
                if (r2_re >= {1'b0, r_d[j-1].den}) begin
                    n_s.x_re = r2_re - {1'b0, r_d[j-1].den};
                    n_s.q_re = {r_d[j-1].q_re[W-2:0], 1'b1};
                end else begin
                    n_s.x_re = r2_re;
                    n_s.q_re = {r_d[j-1].q_re[W-2:0], 1'b0};
                end
                if (r2_im >= {1'b0, r_d[j-1].den}) begin
                    n_s.x_im = r2_im - {1'b0, r_d[j-1].den};
                    n_s.q_im = {r_d[j-1].q_im[W-2:0], 1'b1};
                end else begin
                    n_s.x_im = r2_im;
                    n_s.q_im = {r_d[j-1].q_im[W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d[j] <= n_s;
            end
        end
    end

    // Stage E: rounded magnitude of each part before saturation.
    always_comb begin
        t_sd d;
        d          = r_d[W];
        n_e.eq     = d.eq;
        n_e.dz     = 1'b0;
        n_e.neg_re = 1'b0;
        n_e.neg_im = 1'b0;
        n_e.c_re   = '0;
        n_e.c_im   = '0;
        case (d.op)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_NEG: begin
                n_e.neg_re = d.neg_re;
                n_e.neg_im = d.neg_im;
                n_e.c_re   = {1'b0, d.m_re};
                n_e.c_im   = {1'b0, d.m_im};
            end
            cau_pkg::OP_MUL, cau_pkg::OP_NORM: begin
                n_e.neg_re = d.neg_re;
                n_e.neg_im = d.neg_im;
                n_e.c_re   = ({1'b0, d.m_re} + HALF) >> F;
                n_e.c_im   = ({1'b0, d.m_im} + HALF) >> F;
            end
            cau_pkg::OP_DIV: begin
                if (d.den == '0) begin
                    n_e.dz = 1'b1;
                end else begin
                    n_e.neg_re = d.neg_re;
                    n_e.neg_im = d.neg_im;
                    // Round half away from zero: up when twice the remainder
                    // reaches the divisor.
                    n_e.c_re = d.big_re ? '1 : (MW+1)'(d.q_re)
                               + (MW+1)'({d.x_re[MW-1:0], 1'b0} >= {1'b0, d.den});
                    n_e.c_im = d.big_im ? '1 : (MW+1)'(d.q_im)
                               + (MW+1)'({d.x_im[MW-1:0], 1'b0} >= {1'b0, d.den});
                end
            end
            cau_pkg::OP_MAG: begin
                n_e.c_re = d.x_im + (MW+1)'(d.x_re > d.x_im);
            end
            default: begin
                n_e.c_re = '0;
            end
        endcase
    end

    // Response register: saturate and apply the sign.
    always_ff @(posedge i_clk) begin
        logic [MW:0]  lim_re;
        logic [MW:0]  lim_im;
        logic         sat_re;
        logic         sat_im;
        logic [W-1:0] w_re;
        logic [W-1:0] w_im;
        lim_re = r_e.neg_re ? TOP : TOP - 1'b1;
        lim_im = r_e.neg_im ? TOP : TOP - 1'b1;
        sat_re = r_e.c_re > lim_re;
        sat_im = r_e.c_im > lim_im;
        w_re   = sat_re ? lim_re[W-1:0] : r_e.c_re[W-1:0];
        w_im   = sat_im ? lim_im[W-1:0] : r_e.c_im[W-1:0];
        if (en) begin
            o_rsp.res_re      <= r_e.neg_re ? ('0 - w_re) : w_re;
            o_rsp.res_im      <= r_e.neg_im ? ('0 - w_im) : w_im;
            o_rsp.equal       <= r_e.eq;
            o_rsp.div_by_zero <= r_e.dz;
            o_rsp.overflow    <= sat_re || sat_im;
        end
    end

    assign o_rsp.valid = r_out_vld;

endmodule

FILE: src/complex_arithmetic_unit_top.sv
// Top level of the complex arithmetic unit: front half, request queue and
// back half. Depends on cau_pkg, cau_if, cau_front, cau_fifo and cau_back.
//
//   port    | dir | handshake        | payload
//   i_req   | in  | valid / ready    | opcode, a_re, a_im, b_re, b_im
//   o_rsp   | out | valid / ready    | res_re, res_im, equal, div_by_zero, overflow
//
// One request is taken per cycle unless the queue is full, and one response is
// given per cycle unless o_rsp stalls. A request passes through stages A,
// B and C, the one-bit-per-stage divider and root pipeline, and stage E.
// Reset is synchronous and clears only valid state; no clearing pass follows.
// A stalled response freezes the back pipeline while the four-entry queue
// keeps taking requests until it fills.
`timescale 1ns / 1ps

module complex_arithmetic_unit_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cau_req_if.sink    i_req,
    cau_rsp_if.source  o_rsp
);

    logic              push;
    logic              pop;
    cau_pkg::t_item    item;
    cau_pkg::t_item    head;
    cau_pkg::t_q_stat  stat;

    cau_front u_front (
        .i_req  (i_req),
        .i_stat (stat),
        .o_push (push),
        .o_item (item)
    );

    cau_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (item),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (stat)
    );

    cau_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_stat  (stat),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule
